### rtl/favc_pkg.sv
// ----------------------------------------------------------------------------
// favc_pkg
// shared types, register codes and arithmetic widths for the frustum cull
// ----------------------------------------------------------------------------
package favc_pkg;

    localparam int PLANE_COUNT    = 6;
    localparam int AXES           = 3;
    localparam int PLANE_W        = 64;
    localparam int DATA_W         = 64;
    localparam int ADDR_W         = 6;
    localparam int MASK_W         = 32;
    localparam int COORD_W        = 16;
    localparam int EXT_W          = 15;
    localparam int TOTAL_W        = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // |n| is 17 bits signed, box operand 18 bits signed
    localparam int MAG_W   = 17;
    localparam int OPND_W  = 18;
    localparam int PROD_W  = MAG_W + OPND_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DIST_SH = 14;

    typedef enum logic [2:0] {
        REG_PLANE_LEFT,
        REG_PLANE_RIGHT,
        REG_PLANE_BOTTOM,
        REG_PLANE_TOP,
        REG_PLANE_NEAR,
        REG_PLANE_FAR,
        REG_VIEW_MASK,
        REG_SHADOW_ONLY
    } reg_idx_t;

    typedef logic [PLANE_W-1:0] plane_t;
    typedef logic [PLANE_COUNT-1:0][PLANE_W-1:0] plane_vec_t;

    typedef struct packed {
        logic [MASK_W-1:0] view_mask;
        logic              shadow_only;
    } view_cfg_t;

    typedef struct packed {
        logic update;
        logic vis;
        logic last;
    } cnt_ctrl_t;

endpackage

### rtl/favc_cfg_regs.sv
// ----------------------------------------------------------------------------
// favc_cfg_regs
// apb register file: six packed planes, view layer mask, shadow-only mode
// ----------------------------------------------------------------------------
module favc_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [favc_pkg::ADDR_W-1:0]   paddr,
    input  logic [favc_pkg::DATA_W-1:0]   pwdata,
    output logic [favc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output favc_pkg::plane_vec_t          planes,
    output favc_pkg::view_cfg_t           view_cfg
);
    import favc_pkg::*;

    plane_vec_t        planes_reg;
    logic [MASK_W-1:0] view_mask_reg;
    logic              shadow_only_reg;
    reg_idx_t          idx;
    logic              wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            planes_reg      <= '0;
            view_mask_reg   <= '1;
            shadow_only_reg <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_BOTTOM,
                REG_PLANE_TOP, REG_PLANE_NEAR, REG_PLANE_FAR: begin
                    planes_reg[idx] <= pwdata;
                end
                REG_VIEW_MASK: begin
                    view_mask_reg <= pwdata[MASK_W-1:0];
                end
                REG_SHADOW_ONLY: begin
                    shadow_only_reg <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PLANE_LEFT, REG_PLANE_RIGHT, REG_PLANE_BOTTOM,
            REG_PLANE_TOP, REG_PLANE_NEAR, REG_PLANE_FAR: begin
                prdata = planes_reg[idx];
            end
            REG_VIEW_MASK:   prdata = DATA_W'(view_mask_reg);
            REG_SHADOW_ONLY: prdata = DATA_W'(shadow_only_reg);
            default:         prdata = '0;
        endcase
    end

    assign planes               = planes_reg;
    assign view_cfg.view_mask   = view_mask_reg;
    assign view_cfg.shadow_only = shadow_only_reg;

endmodule

### rtl/favc_plane_test.sv
// ----------------------------------------------------------------------------
// favc_plane_test
// one plane: registered per-axis products, then exact sum and sign test
// ----------------------------------------------------------------------------
module favc_plane_test (
    input  logic                                aclk,
    input  logic                                load_en,
    input  favc_pkg::plane_t                    plane,
    input  logic signed [favc_pkg::COORD_W-1:0] center_x,
    input  logic signed [favc_pkg::COORD_W-1:0] center_y,
    input  logic signed [favc_pkg::COORD_W-1:0] center_z,
    input  logic        [favc_pkg::EXT_W-1:0]   extent_x,
    input  logic        [favc_pkg::EXT_W-1:0]   extent_y,
    input  logic        [favc_pkg::EXT_W-1:0]   extent_z,
    output logic                                pass
);
    import favc_pkg::*;

    logic signed [COORD_W-1:0] nrm      [AXES];
    logic signed [COORD_W-1:0] ctr      [AXES];
    logic        [EXT_W-1:0]   ext      [AXES];
    logic signed [MAG_W-1:0]   nrm_mag  [AXES];
    logic signed [OPND_W-1:0]  ctr_w    [AXES];
    logic signed [OPND_W-1:0]  ext_w    [AXES];
    logic signed [OPND_W-1:0]  opnd     [AXES];
    logic signed [PROD_W-1:0]  prod_next[AXES];
    logic signed [PROD_W-1:0]  prod_reg [AXES];
    logic signed [COORD_W-1:0] dist_reg;
    logic signed [COORD_W+DIST_SH-1:0] dist_sc;
    logic signed [SUM_W-1:0]   sum;

    assign ctr[0] = center_x;
    assign ctr[1] = center_y;
    assign ctr[2] = center_z;
    assign ext[0] = extent_x;
    assign ext[1] = extent_y;
    assign ext[2] = extent_z;

    // n*c + |n|*e folded into |n| * (e + sign(n)*c)
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            nrm[a]     = $signed(plane[COORD_W*a +: COORD_W]);
            nrm_mag[a] = nrm[a][COORD_W-1] ? -$signed({nrm[a][COORD_W-1], nrm[a]})
                                           :  $signed({nrm[a][COORD_W-1], nrm[a]});
            ctr_w[a]   = $signed({{(OPND_W-COORD_W){ctr[a][COORD_W-1]}}, ctr[a]});
            ext_w[a]   = $signed({{(OPND_W-EXT_W){1'b0}}, ext[a]});
            opnd[a]    = nrm[a][COORD_W-1] ? (ext_w[a] - ctr_w[a]) : (ext_w[a] + ctr_w[a]);
            prod_next[a] = PROD_W'(nrm_mag[a]) * PROD_W'(opnd[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (load_en) begin
            for (int a = 0; a < AXES; a++) begin
                prod_reg[a] <= prod_next[a];
            end
            dist_reg <= $signed(plane[PLANE_W-1 -: COORD_W]);
        end
    end

    assign dist_sc = {dist_reg, {DIST_SH{1'b0}}};
    assign sum = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
               + SUM_W'(dist_sc);
    assign pass = !sum[SUM_W-1];

endmodule

### rtl/favc_batch_count.sv
// ----------------------------------------------------------------------------
// favc_batch_count
// saturating visible and culled counters, cleared after the last beat
// ----------------------------------------------------------------------------
module favc_batch_count #(
    parameter int COUNT_WIDTH = favc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  favc_pkg::cnt_ctrl_t            ctrl,
    output logic [favc_pkg::TOTAL_W-1:0]   visible_total,
    output logic [favc_pkg::TOTAL_W-1:0]   culled_total
);
    import favc_pkg::*;

    logic [COUNT_WIDTH-1:0] vis_cnt_reg;
    logic [COUNT_WIDTH-1:0] cul_cnt_reg;
    logic [COUNT_WIDTH-1:0] vis_cnt_inc;
    logic [COUNT_WIDTH-1:0] cul_cnt_inc;

    // count including the current beat
    always_comb begin
        vis_cnt_inc = vis_cnt_reg;
        cul_cnt_inc = cul_cnt_reg;
        if (ctrl.vis) begin
            if (vis_cnt_reg != '1) vis_cnt_inc = vis_cnt_reg + 1'b1;
        end else begin
            if (cul_cnt_reg != '1) cul_cnt_inc = cul_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_cnt_reg <= '0;
            cul_cnt_reg <= '0;
        end else if (ctrl.update) begin
            vis_cnt_reg <= ctrl.last ? '0 : vis_cnt_inc;
            cul_cnt_reg <= ctrl.last ? '0 : cul_cnt_inc;
        end
    end

    generate
        if (COUNT_WIDTH > TOTAL_W) begin : g_clamp
            assign visible_total = (|vis_cnt_inc[COUNT_WIDTH-1:TOTAL_W]) ? '1
                                 : vis_cnt_inc[TOTAL_W-1:0];
            assign culled_total  = (|cul_cnt_inc[COUNT_WIDTH-1:TOTAL_W]) ? '1
                                 : cul_cnt_inc[TOTAL_W-1:0];
        end else begin : g_plain
            assign visible_total = TOTAL_W'(vis_cnt_inc);
            assign culled_total  = TOTAL_W'(cul_cnt_inc);
        end
    endgenerate

endmodule

### rtl/frustum_aabb_visibility_cull.sv
// ----------------------------------------------------------------------------
// frustum_aabb_visibility_cull
// object visibility: layer, flag and six-plane box test with batch counters
// ----------------------------------------------------------------------------
// path: three registered stages, input, plane products and result
// throughput: one object per cycle while the sink is ready; the stages each
//   hand on independently, so bubbles close under back-pressure
// reset: aresetn synchronous active low; empties the pipe, clears both batch
//   counters, planes to zero, view layer mask to all ones, shadow-only off
// ----------------------------------------------------------------------------
module frustum_aabb_visibility_cull #(
    parameter int COUNT_WIDTH = favc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // apb config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [favc_pkg::ADDR_W-1:0]         paddr,
    input  logic [favc_pkg::DATA_W-1:0]         pwdata,
    output logic [favc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    // object input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [favc_pkg::COORD_W-1:0] s_center_x,
    input  logic signed [favc_pkg::COORD_W-1:0] s_center_y,
    input  logic signed [favc_pkg::COORD_W-1:0] s_center_z,
    input  logic        [favc_pkg::EXT_W-1:0]   s_extent_x,
    input  logic        [favc_pkg::EXT_W-1:0]   s_extent_y,
    input  logic        [favc_pkg::EXT_W-1:0]   s_extent_z,
    input  logic                                s_bounds_valid,
    input  logic        [favc_pkg::MASK_W-1:0]  s_object_layers,
    input  logic                                s_flag_visible,
    input  logic                                s_flag_shadow_caster,
    input  logic                                s_last_in_batch,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_visible,
    output logic        [favc_pkg::TOTAL_W-1:0] m_visible_total,
    output logic        [favc_pkg::TOTAL_W-1:0] m_culled_total,
    output logic                                m_batch_end
);
    import favc_pkg::*;

    plane_vec_t planes;
    view_cfg_t  view_cfg;

    // stage 1: input register
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] s1_center_x_reg, s1_center_y_reg, s1_center_z_reg;
    logic        [EXT_W-1:0]   s1_extent_x_reg, s1_extent_y_reg, s1_extent_z_reg;
    logic                      s1_bounds_valid_reg;
    logic        [MASK_W-1:0]  s1_layers_reg;
    logic                      s1_flag_vis_reg;
    logic                      s1_flag_sh_reg;
    logic                      s1_last_reg;

    // stage 2: products held inside the plane units
    logic                      s2_valid_reg;
    logic                      s2_attr_ok_reg;
    logic                      s2_bounds_valid_reg;
    logic                      s2_last_reg;

    // result register
    logic                      m_valid_reg;
    logic                      m_is_visible_reg;
    logic [TOTAL_W-1:0]        m_visible_total_reg;
    logic [TOTAL_W-1:0]        m_culled_total_reg;
    logic                      m_batch_end_reg;

    logic                      out_room;
    logic                      s2_ready;
    logic                      s2_adv;
    logic                      s1_adv;
    logic                      s_accept;
    logic                      s1_attr_ok;
    logic [PLANE_COUNT-1:0]    plane_pass;
    logic                      s2_vis;
    cnt_ctrl_t                 cnt_ctrl;
    logic [TOTAL_W-1:0]        visible_total;
    logic [TOTAL_W-1:0]        culled_total;

    favc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .planes   (planes),
        .view_cfg (view_cfg)
    );

    // each stage moves on when the one after it has room
    assign out_room = !m_valid_reg || m_ready;
    assign s2_adv   = s2_valid_reg && out_room;
    assign s2_ready = !s2_valid_reg || out_room;
    assign s1_adv   = s1_valid_reg && s2_ready;
    assign s_ready  = !s1_valid_reg || s2_ready;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_center_x_reg     <= s_center_x;
            s1_center_y_reg     <= s_center_y;
            s1_center_z_reg     <= s_center_z;
            s1_extent_x_reg     <= s_extent_x;
            s1_extent_y_reg     <= s_extent_y;
            s1_extent_z_reg     <= s_extent_z;
            s1_bounds_valid_reg <= s_bounds_valid;
            s1_layers_reg       <= s_object_layers;
            s1_flag_vis_reg     <= s_flag_visible;
            s1_flag_sh_reg      <= s_flag_shadow_caster;
            s1_last_reg         <= s_last_in_batch;
        end
    end

    // layer overlap and flag checks need no arithmetic, done in stage 1
    assign s1_attr_ok = (|(s1_layers_reg & view_cfg.view_mask)) && s1_flag_vis_reg
                     && (!view_cfg.shadow_only || s1_flag_sh_reg);

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s2_attr_ok_reg      <= s1_attr_ok;
            s2_bounds_valid_reg <= s1_bounds_valid_reg;
            s2_last_reg         <= s1_last_reg;
        end
    end

    // six plane units in parallel, products registered with stage 2
    generate
        for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
            favc_plane_test u_plane (
                .aclk     (aclk),
                .load_en  (s1_adv),
                .plane    (planes[p]),
                .center_x (s1_center_x_reg),
                .center_y (s1_center_y_reg),
                .center_z (s1_center_z_reg),
                .extent_x (s1_extent_x_reg),
                .extent_y (s1_extent_y_reg),
                .extent_z (s1_extent_z_reg),
                .pass     (plane_pass[p])
            );
        end
    endgenerate

    // unknown bounds pass the box test
    assign s2_vis = s2_attr_ok_reg && (!s2_bounds_valid_reg || (&plane_pass));

    assign cnt_ctrl.update = s2_adv;
    assign cnt_ctrl.vis    = s2_vis;
    assign cnt_ctrl.last   = s2_last_reg;

    favc_batch_count #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctrl          (cnt_ctrl),
        .visible_total (visible_total),
        .culled_total  (culled_total)
    );

    // valid flags and result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready)  s1_valid_reg <= s_valid;
            if (s2_ready) s2_valid_reg <= s1_valid_reg;
            if (out_room) m_valid_reg  <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_adv) begin
            m_is_visible_reg    <= s2_vis;
            m_visible_total_reg <= visible_total;
            m_culled_total_reg  <= culled_total;
            m_batch_end_reg     <= s2_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_visible    = m_is_visible_reg;
    assign m_visible_total = m_visible_total_reg;
    assign m_culled_total  = m_culled_total_reg;
    assign m_batch_end     = m_batch_end_reg;

    // every result beat counts its own object
    a_total_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_adv |=> (m_visible_total != '0 || m_culled_total != '0))
        else $error("result beat with both totals zero");

    // a visible object shows up in the visible total
    a_visible_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_visible) |-> (m_visible_total != '0))
        else $error("visible beat with zero visible total");

    // a culled object shows up in the culled total
    a_culled_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_visible) |-> (m_culled_total != '0))
        else $error("culled beat with zero culled total");

    // input stalls only with every stage full
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s2_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled with room in the pipe");

endmodule

### dv/frustum_aabb_visibility_cull_tb.sv
// ----------------------------------------------------------------------------
// frustum_aabb_visibility_cull_tb
// self-checking bench for the object visibility cull: drives object beats and
// apb register writes, predicts every result beat in-bench (layer, flag and
// six-plane box test plus the saturating batch counters) and compares each
// result beat field by field under random source gaps and sink stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frustum_aabb_visibility_cull_tb;

    import favc_pkg::*;

    localparam int          PIPE_LATENCY  = 3;
    localparam int          QUIET_LIMIT   = 4000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          HOLD_AFTER    = 300;
    localparam int          RANDOM_ROUNDS = 6;
    localparam int          ROUND_OBJECTS = 185;
    localparam int          FULL_RUN      = 40;
    localparam int unsigned CNT_MAX       = (1 << COUNT_WIDTH_DEF) - 1;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_z;
        logic [EXT_W-1:0]   extent_x;
        logic [EXT_W-1:0]   extent_y;
        logic [EXT_W-1:0]   extent_z;
        logic               bounds_valid;
        logic [MASK_W-1:0]  layers;
        logic               flag_visible;
        logic               flag_shadow;
        logic               last_in_batch;
    } object_t;

    typedef struct packed {
        logic               is_visible;
        logic [TOTAL_W-1:0] visible_total;
        logic [TOTAL_W-1:0] culled_total;
        logic               batch_end;
    } verdict_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SPARSE,
        RX_CHOPPY,
        RX_TRICKLE
    } rx_pattern_t;

    // clock, reset and dut pins
    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    object_t             s_obj   = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_is_visible;
    logic [TOTAL_W-1:0]  m_visible_total;
    logic [TOTAL_W-1:0]  m_culled_total;
    logic                m_batch_end;

    // bench-side copy of the register file, updated on every apb write
    logic [PLANE_W-1:0]  plane_regs [PLANE_COUNT];
    logic [MASK_W-1:0]   view_mask_reg;
    logic                shadow_only_reg;

    // batch counters as the block should hold them
    int unsigned         visible_count;
    int unsigned         culled_count;

    object_t             object_queue [$];   // objects waiting to be offered
    verdict_t            verdict_queue [$];  // results owed by the block

    int                  mismatches    = 0;
    int                  objects_taken = 0;
    int                  results_seen  = 0;
    int                  batches_seen  = 0;
    int                  setups_done   = 0;
    int                  quiet_cycles  = 0;
    logic                s_took        = 1'b0;
    logic                full_rate     = 1'b0;

    // source pacing
    int                  burst_left    = 1;
    int                  gap_left      = 0;

    // sink pacing
    logic [31:0]         rx_tick       = '0;
    rx_pattern_t         rx_pattern    = RX_OPEN;
    int                  hold_left     = 0;
    logic                hold_done     = 1'b0;

    always #5 aclk = ~aclk;

    frustum_aabb_visibility_cull i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_center_x           (s_obj.center_x),
        .s_center_y           (s_obj.center_y),
        .s_center_z           (s_obj.center_z),
        .s_extent_x           (s_obj.extent_x),
        .s_extent_y           (s_obj.extent_y),
        .s_extent_z           (s_obj.extent_z),
        .s_bounds_valid       (s_obj.bounds_valid),
        .s_object_layers      (s_obj.layers),
        .s_flag_visible       (s_obj.flag_visible),
        .s_flag_shadow_caster (s_obj.flag_shadow),
        .s_last_in_batch      (s_obj.last_in_batch),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_is_visible         (m_is_visible),
        .m_visible_total      (m_visible_total),
        .m_culled_total       (m_culled_total),
        .m_batch_end          (m_batch_end)
    );

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // box is rejected by a plane when the farthest corner along the normal
    // still lies on the negative side; all terms are exact Q.14 products
    function automatic logic box_in_frustum(object_t o);
        longint nx, ny, nz, plane_d, reach;
        if (!o.bounds_valid) return 1'b1;       // unknown box always passes
        for (int p = 0; p < PLANE_COUNT; p++) begin
            nx      = longint'(shortint'(plane_regs[p][15:0]));
            ny      = longint'(shortint'(plane_regs[p][31:16]));
            nz      = longint'(shortint'(plane_regs[p][47:32]));
            plane_d = longint'(shortint'(plane_regs[p][63:48]));
            reach = nx * longint'(shortint'(o.center_x))
                  + ny * longint'(shortint'(o.center_y))
                  + nz * longint'(shortint'(o.center_z))
                  + plane_d * 16384
                  + ((nx < 0) ? -nx : nx) * longint'(o.extent_x)
                  + ((ny < 0) ? -ny : ny) * longint'(o.extent_y)
                  + ((nz < 0) ? -nz : nz) * longint'(o.extent_z);
            if (reach < 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // verdict for one object; advances the batch counters as the block does
    function automatic verdict_t judge_object(object_t o);
        verdict_t v;
        logic     seen;
        seen = ((o.layers & view_mask_reg) != '0) && o.flag_visible
            && (!shadow_only_reg || o.flag_shadow) && box_in_frustum(o);
        if (seen) begin
            if (visible_count < CNT_MAX) visible_count++;
        end else if (culled_count < CNT_MAX) begin
            culled_count++;
        end
        v.is_visible    = seen;
        v.visible_total = (visible_count > 16'hFFFF) ? 16'hFFFF : visible_count[15:0];
        v.culled_total  = (culled_count > 16'hFFFF) ? 16'hFFFF : culled_count[15:0];
        v.batch_end     = o.last_in_batch;
        // totals include this object, then both counters restart
        if (o.last_in_batch) begin
            visible_count = 0;
            culled_count  = 0;
        end
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] reg_readback(reg_idx_t idx);
        case (idx)
            REG_VIEW_MASK:   return {{(DATA_W-MASK_W){1'b0}}, view_mask_reg};
            REG_SHADOW_ONLY: return {{(DATA_W-1){1'b0}}, shadow_only_reg};
            default:         return plane_regs[idx];
        endcase
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic void queue_object(object_t o);
        object_queue.insert(object_queue.size(), o);
    endfunction

    function automatic object_t make_object(logic [15:0] cx, logic [15:0] cy,
                                            logic [15:0] cz, logic [14:0] ex,
                                            logic [14:0] ey, logic [14:0] ez,
                                            logic bv, logic [31:0] layers,
                                            logic vis, logic shadow, logic last);
        object_t o;
        o = '{cx, cy, cz, ex, ey, ez, bv, layers, vis, shadow, last};
        return o;
    endfunction

    // plane with q1.14 normal components in [-1, 1] and a modest distance,
    // sometimes fully random bits, sometimes the all-zero always-pass plane
    function automatic logic [PLANE_W-1:0] random_plane();
        logic [15:0] nx, ny, nz, ofs;
        case ($urandom_range(0, 5))
            0, 1: return '0;
            2:    return {$urandom, $urandom};
            default: begin
                nx  = 16'($urandom_range(0, 32768) - 16384);
                ny  = 16'($urandom_range(0, 32768) - 16384);
                nz  = 16'($urandom_range(0, 32768) - 16384);
                ofs = 16'($urandom_range(0, 3072) - 512);
                return {ofs, nz, ny, nx};
            end
        endcase
    endfunction

    // mostly small boxes near the origin so plane tests land on both sides,
    // with a share of full-range coordinates and extents
    function automatic object_t random_object();
        object_t o;
        if ($urandom_range(0, 3) == 0) begin
            o.center_x = 16'($urandom);
            o.center_y = 16'($urandom);
            o.center_z = 16'($urandom);
        end else begin
            o.center_x = 16'($urandom_range(0, 4095) - 2048);
            o.center_y = 16'($urandom_range(0, 4095) - 2048);
            o.center_z = 16'($urandom_range(0, 4095) - 2048);
        end
        if ($urandom_range(0, 3) == 0) begin
            o.extent_x = 15'($urandom);
            o.extent_y = 15'($urandom);
            o.extent_z = 15'($urandom);
        end else begin
            o.extent_x = 15'($urandom_range(0, 512));
            o.extent_y = 15'($urandom_range(0, 512));
            o.extent_z = 15'($urandom_range(0, 512));
        end
        o.bounds_valid = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 3))
            0:       o.layers = '0;
            1:       o.layers = 32'h1 << $urandom_range(0, 31);
            default: o.layers = $urandom;
        endcase
        o.flag_visible  = ($urandom_range(0, 3) != 0);
        o.flag_shadow   = 1'($urandom_range(0, 1));
        o.last_in_batch = ($urandom_range(0, 19) == 0);
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // apb access, changed on the falling edge, write lands on the access edge
    // ------------------------------------------------------------------------

    task automatic check_reg(reg_idx_t idx);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 3'b000};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== reg_readback(idx))
            note_mismatch($sformatf("readback %s", idx.name()), prdata, reg_readback(idx));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_VIEW_MASK:   view_mask_reg   = value[MASK_W-1:0];
            REG_SHADOW_ONLY: shadow_only_reg = value[0];
            default:         plane_regs[idx] = value;
        endcase
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        check_reg(idx);
    endtask

    task automatic random_setup();
        logic [MASK_W-1:0] mask;
        for (int p = 0; p < PLANE_COUNT; p++)
            write_reg(reg_idx_t'(p), random_plane());
        case ($urandom_range(0, 5))
            0:       mask = '0;
            1, 2:    mask = '1;
            3:       mask = 32'h1 << $urandom_range(0, 31);
            default: mask = $urandom;
        endcase
        // upper data bits are junk on purpose, only the low bits are kept
        write_reg(REG_VIEW_MASK, {32'($urandom), mask});
        write_reg(REG_SHADOW_ONLY, {$urandom, $urandom});
        setups_done++;
    endtask

    // the sender waits here until every owed result is back and the pipe
    // has had time to empty
    task automatic drain();
        while (object_queue.size() != 0 || s_valid || verdict_queue.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // object driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (s_valid && !s_took) begin
            // offered beat not taken yet, hold it steady
        end else if (!full_rate && gap_left != 0) begin
            s_valid  <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (object_queue.size() != 0) begin
            s_obj   <= object_queue.pop_front();
            s_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 24);
                // a third of the bursts follow on with no gap at all
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            s_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: stall pattern is redrawn each time rx_tick[8:0] wraps, plus one long
    // hold-off so the pipe fills and back-pressures the object channel
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick[8:0] == '0)
            rx_pattern <= rx_pattern_t'($urandom_range(0, 3));
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && !full_rate && results_seen >= HOLD_AFTER) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (full_rate) begin
            m_ready <= 1'b1;
        end else begin
            case (rx_pattern)
                RX_OPEN:    m_ready <= 1'b1;
                RX_SPARSE:  m_ready <= ($urandom_range(0, 2) != 0);
                RX_CHOPPY:  m_ready <= (rx_tick[1:0] == 2'b00);
                RX_TRICKLE: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sampling on the rising edge: predict on each object beat, compare on
    // each result beat
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        verdict_t want;
        s_took <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            verdict_queue.insert(verdict_queue.size(), judge_object(s_obj));
            objects_taken++;
            if (s_obj.last_in_batch) batches_seen++;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (verdict_queue.size() == 0) begin
                note_mismatch("result beat with nothing owed", m_is_visible, 0);
            end else begin
                want = verdict_queue.pop_front();
                if (m_is_visible !== want.is_visible)
                    note_mismatch("is_visible", m_is_visible, want.is_visible);
                if (m_visible_total !== want.visible_total)
                    note_mismatch("visible_total", m_visible_total, want.visible_total);
                if (m_culled_total !== want.culled_total)
                    note_mismatch("culled_total", m_culled_total, want.culled_total);
                if (m_batch_end !== want.batch_end)
                    note_mismatch("batch_end", m_batch_end, want.batch_end);
            end
        end
    end

    // watchdog: too long with no beat moving on either channel or the apb
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: %0d cycles with no beat, %0d results still owed",
                     quiet_cycles, verdict_queue.size());
            $display("frustum_aabb_visibility_cull: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int p = 0; p < PLANE_COUNT; p++) plane_regs[p] = '0;
        view_mask_reg   = '1;
        shadow_only_reg = 1'b0;
        visible_count   = 0;
        culled_count    = 0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset values of every register
        for (int r = 0; r <= int'(REG_SHADOW_ONLY); r++)
            check_reg(reg_idx_t'(r));

        // reset setup: zero planes pass everything, only layers and flags cull
        queue_object(make_object(16'h8000, 16'h8000, 16'h8000, 15'h7FFF,
                     15'h7FFF, 15'h7FFF, 1'b1, '1, 1'b1, 1'b0, 1'b0));
        queue_object(make_object(16'h7FFF, 16'h7FFF, 16'h7FFF, '0, '0, '0,
                     1'b1, 32'h0000_0001, 1'b1, 1'b0, 1'b0));
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, '0,
                     1'b1, 1'b1, 1'b0));                  // no layer
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, '1,
                     1'b0, 1'b1, 1'b0));                  // hidden flag
        queue_object(make_object(16'h1234, 16'hEDCB, 16'h0F0F, 15'h5555,
                     15'h2AAA, 15'h0001, 1'b0, 32'h8000_0000, 1'b1, 1'b0,
                     1'b1));                              // closes batch
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, 32'hFFFF_0000,
                     1'b1, 1'b0, 1'b0));                  // fresh counters
        drain();

        // single plane x >= 0 (unit normal, zero distance), layers 4-7 only,
        // shadow casters only
        write_reg(REG_PLANE_LEFT, {16'h0000, 16'h0000, 16'h0000, 16'h4000});
        for (int p = int'(REG_PLANE_RIGHT); p <= int'(REG_PLANE_FAR); p++)
            write_reg(reg_idx_t'(p), '0);
        write_reg(REG_VIEW_MASK, {32'hFFFF_FFFF, 32'h0000_00F0});
        write_reg(REG_SHADOW_ONLY, 64'h1);
        setups_done++;
        // corner exactly on the plane passes, one lsb further out fails
        queue_object(make_object(16'hFFF0, '0, '0, 15'd16, '0, '0, 1'b1,
                     32'h10, 1'b1, 1'b1, 1'b0));
        queue_object(make_object(16'hFFEF, '0, '0, 15'd16, '0, '0, 1'b1,
                     32'h10, 1'b1, 1'b1, 1'b0));
        // same outside box with unknown bounds
        queue_object(make_object(16'hFFEF, '0, '0, 15'd16, '0, '0, 1'b0,
                     32'h10, 1'b1, 1'b1, 1'b0));
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, 32'h10,
                     1'b1, 1'b0, 1'b0));                  // not a caster
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, 32'h0F,
                     1'b1, 1'b1, 1'b0));                  // layer miss
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, 32'h80,
                     1'b1, 1'b1, 1'b0));
        queue_object(make_object(16'h8000, '0, '0, 15'h7FFF, '0, '0, 1'b1,
                     '1, 1'b1, 1'b1, 1'b0));
        queue_object(make_object(16'h7FFF, '0, '0, '0, '0, '0, 1'b1, '1,
                     1'b1, 1'b1, 1'b1));
        drain();

        // extreme planes: most negative, most positive and all-ones packing
        write_reg(REG_PLANE_LEFT,   64'h8000_8000_8000_8000);
        write_reg(REG_PLANE_RIGHT,  64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_PLANE_BOTTOM, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_VIEW_MASK,    64'h0000_0000_FFFF_FFFF);
        write_reg(REG_SHADOW_ONLY,  64'h0);
        setups_done++;
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, '1,
                     1'b1, 1'b0, 1'b0));
        queue_object(make_object(16'h8000, 16'h8000, 16'h8000, 15'h7FFF,
                     15'h7FFF, 15'h7FFF, 1'b1, '1, 1'b1, 1'b0, 1'b0));
        queue_object(make_object(16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF,
                     15'h7FFF, 15'h7FFF, 1'b1, '1, 1'b1, 1'b1, 1'b0));
        queue_object(make_object(16'h7FFF, 16'h7FFF, 16'h7FFF, '0, '0, '0,
                     1'b0, '1, 1'b1, 1'b0, 1'b1));
        drain();

        // random rounds, each under its own register setting; the long sink
        // hold-off lands inside the second round
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            random_setup();
            repeat (ROUND_OBJECTS) queue_object(random_object());
            drain();
        end

        // one batch at full rate with the sink always ready: a visible run,
        // then a culled run, then the batch end clears both counters
        for (int p = 0; p < PLANE_COUNT; p++) write_reg(reg_idx_t'(p), '0);
        write_reg(REG_VIEW_MASK, '1);
        write_reg(REG_SHADOW_ONLY, '0);
        setups_done++;
        full_rate = 1'b1;
        repeat (FULL_RUN) queue_object(make_object(16'($urandom), '0, '0,
                          15'($urandom), '0, '0, 1'b1, '1, 1'b1, 1'b0, 1'b0));
        repeat (FULL_RUN) queue_object(make_object(16'($urandom), '0, '0,
                          15'($urandom), '0, '0, 1'b1, '1, 1'b0, 1'b0, 1'b0));
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, '1, 1'b0,
                     1'b0, 1'b1));
        queue_object(make_object('0, '0, '0, '0, '0, '0, 1'b1, '1, 1'b1,
                     1'b0, 1'b0));
        drain();
        full_rate = 1'b0;

        // a last random round after the full-rate batch
        random_setup();
        repeat (ROUND_OBJECTS) queue_object(random_object());
        drain();

        if (verdict_queue.size() != 0)
            note_mismatch("results never delivered", 0, verdict_queue.size());

        $display("covered %0d objects in %0d closed batches over %0d register settings,",
                 objects_taken, batches_seen, setups_done);
        $display("incl. plane extremes, unknown bounds and a full-rate batch; %0d bad",
                 mismatches);
        if (mismatches == 0) begin
            $display("frustum_aabb_visibility_cull: match");
        end else begin
            $display("frustum_aabb_visibility_cull: mismatch");
        end
        $finish;
    end

endmodule

### frustum_aabb_visibility_cull.f
rtl/favc_pkg.sv
rtl/favc_cfg_regs.sv
rtl/favc_plane_test.sv
rtl/favc_batch_count.sv
rtl/frustum_aabb_visibility_cull.sv
dv/frustum_aabb_visibility_cull_tb.sv
